// ----- sv/assert_macros.svh -----
// Assertion helpers, clocked on clock and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// cond must never be seen
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ----- sv/whp_pkg.sv -----
`default_nettype none

package whp_pkg;

   // result status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_TOO_SMALL = 3'd1;
   localparam logic [2:0] STAT_NOT_RIFF  = 3'd2;
   localparam logic [2:0] STAT_NOT_WAVE  = 3'd3;
   localparam logic [2:0] STAT_NOT_PCM   = 3'd4;
   localparam logic [2:0] STAT_NOT_16BIT = 3'd5;
   localparam logic [2:0] STAT_NO_DATA   = 3'd6;
   localparam logic [2:0] STAT_ZERO_CH   = 3'd7;

   // tags, first file byte in the low lane
   localparam logic [31:0] TAG_RIFF_LE = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE_LE = 32'h4556_4157;
   // "data" as shifted in, first byte highest
   localparam logic [31:0] TAG_DATA    = 32'h6461_7461;

   localparam logic [7:0]  PCM_FORMAT  = 8'd1;
   localparam logic [7:0]  PCM_DEPTH   = 8'd16;
   localparam logic [31:0] FMT_BASE    = 32'd16;
   localparam logic [31:0] CHDR_BYTES  = 32'd8;
   localparam logic [31:0] CHDR_TAG_END = 32'd4;
   localparam logic [31:0] HDR_BYTES   = 32'd36;
   localparam logic [31:0] MIN_LAST    = 32'd43;
   localparam logic [31:0] IDX_MAX     = 32'hFFFF_FFFF;

   localparam int DIV_STEPS = 32;

   function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] lane);
      tag_byte = tag[{lane, 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

// ----- sv/wav_header_parser_core.sv -----
`default_nettype none
`include "assert_macros.svh"

// WAV header parser. Bytes of one file stream in on req_* (tlast on the final
// byte); one result per file comes out on rsp_*. The 44-byte canonical header
// is checked (RIFF, WAVE, PCM format 1, 16-bit depth), extra format bytes are
// skipped and chunk headers are walked until the "data" chunk, whose header
// must be followed by at least one more byte. Header errors are held and
// reported on byte 44; a file ending before byte 44 reports too small; a file
// ending before the data chunk reports no data; zero channels reports status 7
// with frame_count zero. Bytes after the result are dropped until tlast, and
// tlast always rearms the parser for the next file. Rate: one byte per clock.
// When the data chunk is found with a nonzero channel count the frame count
// comes from a restoring divider that retires one quotient bit per clock,
// so req_tready stays low while it runs and the result appears when it
// finishes. req_tready also waits for a pending result to be taken (it
// follows rsp_tready in the same cycle).
module wav_header_parser_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] file_byte
   input  wire logic         req_tlast,   // last_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [143:0]      rsp_tdata,   // [15:0] channel_count, [47:16] rate_hz,
                                          // [79:48] payload_offset,
                                          // [111:80] payload_bytes,
                                          // [143:112] frame_count
   output logic [2:0]        rsp_tuser    // [2:0] status
);

   typedef enum logic [1:0] {PH_HEADER, PH_FMTSKIP, PH_CHDR, PH_BODY} phase_type;
   typedef enum logic {ST_IDLE, ST_DIV} ctl_type;

   localparam int CNT_W = $clog2(whp_pkg::DIV_STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(whp_pkg::DIV_STEPS - 1);

   // parser state
   logic [31:0] byte_index_ff, byte_index_in;
   phase_type   phase_ff, phase_in;
   logic [2:0]  held_error_ff, held_error_in;
   logic [31:0] fmt_length_ff, fmt_length_in;
   logic [15:0] chans_ff, chans_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] skip_left_ff, skip_left_in;
   logic [31:0] chunk_tag_ff, chunk_tag_in;
   logic [31:0] chunk_len_ff, chunk_len_in;
   logic        done_ff, done_in;

   // divider
   ctl_type          st_ff, st_in;
   logic [31:0]      quo_ff, quo_in;
   logic [17:0]      rem_ff, rem_in;
   logic [16:0]      divisor_ff, divisor_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_chans_ff, rsp_chans_in;
   logic [31:0] rsp_rate_ff, rsp_rate_in;
   logic [31:0] rsp_off_ff, rsp_off_in;
   logic [31:0] rsp_bytes_ff, rsp_bytes_in;
   logic [31:0] rsp_frames_ff, rsp_frames_in;

   logic        accept;
   logic [7:0]  b;
   logic        last;
   logic        in_header;
   logic [31:0] skip_dec;
   logic [31:0] tag_nx;
   logic [31:0] len_nx;
   logic        found;
   logic [31:0] off_nx;
   logic [17:0] rem_shift;
   logic [18:0] rem_diff;
   logic        q_bit;

   assign req_tready = (st_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign last       = req_tlast;
   assign in_header  = byte_index_ff < whp_pkg::HDR_BYTES;

   // chunk walker, next values for the current byte
   assign skip_dec = (skip_left_ff != 32'd0) ? skip_left_ff - 32'd1 : skip_left_ff;
   assign tag_nx   = (skip_left_ff > whp_pkg::CHDR_TAG_END) ?
                     {chunk_tag_ff[23:0], b} : chunk_tag_ff;
   assign len_nx   = (skip_left_ff > whp_pkg::CHDR_TAG_END) ?
                     chunk_len_ff : {b, chunk_len_ff[31:8]};
   assign found    = !in_header && (phase_ff == PH_CHDR) && (skip_dec == 32'd0) &&
                     !last && (tag_nx == whp_pkg::TAG_DATA);
   assign off_nx   = (byte_index_ff == whp_pkg::IDX_MAX) ? byte_index_ff :
                     byte_index_ff + 32'd1;

   // one restoring step
   assign rem_shift = {rem_ff[16:0], quo_ff[31]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, divisor_ff};
   assign q_bit     = !rem_diff[18];

   always_comb begin
      byte_index_in = byte_index_ff;
      phase_in      = phase_ff;
      held_error_in = held_error_ff;
      fmt_length_in = fmt_length_ff;
      chans_in      = chans_ff;
      rate_in       = rate_ff;
      skip_left_in  = skip_left_ff;
      chunk_tag_in  = chunk_tag_ff;
      chunk_len_in  = chunk_len_ff;
      done_in       = done_ff;
      st_in         = st_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_chans_in  = rsp_chans_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_frames_in = rsp_frames_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (st_ff == ST_DIV) begin
         rem_in     = q_bit ? rem_diff[17:0] : rem_shift;
         quo_in     = {quo_ff[30:0], q_bit};
         div_cnt_in = div_cnt_ff + 1'b1;
         if (div_cnt_ff == CNT_LAST) begin
            st_in         = ST_IDLE;
            rsp_frames_in = {quo_ff[30:0], q_bit};
            rsp_valid_in  = 1'b1;
         end
      end

      if (accept) begin
         if (!done_ff) begin
            if (in_header) begin
               case (byte_index_ff[5:0])
                  6'd0, 6'd1, 6'd2, 6'd3: begin
                     if (b != whp_pkg::tag_byte(whp_pkg::TAG_RIFF_LE, byte_index_ff[1:0]) &&
                         held_error_ff == whp_pkg::STAT_OK) begin
                        held_error_in = whp_pkg::STAT_NOT_RIFF;
                     end
                  end
                  6'd8, 6'd9, 6'd10, 6'd11: begin
                     if (b != whp_pkg::tag_byte(whp_pkg::TAG_WAVE_LE, byte_index_ff[1:0]) &&
                         held_error_ff == whp_pkg::STAT_OK) begin
                        held_error_in = whp_pkg::STAT_NOT_WAVE;
                     end
                  end
                  6'd16, 6'd17, 6'd18, 6'd19: begin
                     fmt_length_in[{byte_index_ff[1:0], 3'b000} +: 8] =
                        fmt_length_ff[{byte_index_ff[1:0], 3'b000} +: 8] | b;
                  end
                  6'd20: begin
                     if (b != whp_pkg::PCM_FORMAT && held_error_ff == whp_pkg::STAT_OK) begin
                        held_error_in = whp_pkg::STAT_NOT_PCM;
                     end
                  end
                  6'd21: begin
                     if (b != 8'd0 && held_error_ff == whp_pkg::STAT_OK) begin
                        held_error_in = whp_pkg::STAT_NOT_PCM;
                     end
                  end
                  6'd22, 6'd23: begin
                     chans_in[{byte_index_ff[0], 3'b000} +: 8] =
                        chans_ff[{byte_index_ff[0], 3'b000} +: 8] | b;
                  end
                  6'd24, 6'd25, 6'd26, 6'd27: begin
                     rate_in[{byte_index_ff[1:0], 3'b000} +: 8] =
                        rate_ff[{byte_index_ff[1:0], 3'b000} +: 8] | b;
                  end
                  6'd34: begin
                     if (b != whp_pkg::PCM_DEPTH && held_error_ff == whp_pkg::STAT_OK) begin
                        held_error_in = whp_pkg::STAT_NOT_16BIT;
                     end
                  end
                  6'd35: begin
                     if (b != 8'd0 && held_error_ff == whp_pkg::STAT_OK) begin
                        held_error_in = whp_pkg::STAT_NOT_16BIT;
                     end
                     // format length is complete by now
                     if (fmt_length_ff > whp_pkg::FMT_BASE) begin
                        phase_in     = PH_FMTSKIP;
                        skip_left_in = fmt_length_ff - whp_pkg::FMT_BASE;
                     end else begin
                        phase_in     = PH_CHDR;
                        skip_left_in = whp_pkg::CHDR_BYTES;
                        chunk_tag_in = 32'd0;
                        chunk_len_in = 32'd0;
                     end
                  end
                  default: begin
                  end
               endcase
            end else begin
               case (phase_ff)
                  PH_FMTSKIP, PH_BODY: begin
                     skip_left_in = skip_dec;
                     if (skip_dec == 32'd0) begin
                        phase_in     = PH_CHDR;
                        skip_left_in = whp_pkg::CHDR_BYTES;
                        chunk_tag_in = 32'd0;
                        chunk_len_in = 32'd0;
                     end
                  end
                  PH_CHDR: begin
                     chunk_tag_in = tag_nx;
                     chunk_len_in = len_nx;
                     skip_left_in = skip_dec;
                     // non-data chunk: skip its body, or go straight to the next header
                     if (skip_dec == 32'd0 && !last && tag_nx != whp_pkg::TAG_DATA) begin
                        if (len_nx == 32'd0) begin
                           skip_left_in = whp_pkg::CHDR_BYTES;
                           chunk_tag_in = 32'd0;
                           chunk_len_in = 32'd0;
                        end else begin
                           phase_in     = PH_BODY;
                           skip_left_in = len_nx;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end

            // result fields see this byte's header captures
            rsp_chans_in  = chans_in;
            rsp_rate_in   = rate_in;
            rsp_off_in    = 32'd0;
            rsp_bytes_in  = 32'd0;
            rsp_frames_in = 32'd0;
            if (last && byte_index_ff < whp_pkg::MIN_LAST) begin
               rsp_status_in = whp_pkg::STAT_TOO_SMALL;
               rsp_valid_in  = 1'b1;
               done_in       = 1'b1;
            end else if (byte_index_ff == whp_pkg::MIN_LAST &&
                         held_error_ff != whp_pkg::STAT_OK) begin
               rsp_status_in = held_error_ff;
               rsp_valid_in  = 1'b1;
               done_in       = 1'b1;
            end else if (found) begin
               rsp_off_in   = off_nx;
               rsp_bytes_in = len_nx;
               done_in      = 1'b1;
               if (chans_ff == 16'd0) begin
                  rsp_status_in = whp_pkg::STAT_ZERO_CH;
                  rsp_valid_in  = 1'b1;
               end else begin
                  // frame_count = bytes / (2 * channels), filled in by the divider
                  rsp_status_in = whp_pkg::STAT_OK;
                  st_in         = ST_DIV;
                  quo_in        = len_nx;
                  rem_in        = 18'd0;
                  divisor_in    = {chans_ff, 1'b0};
                  div_cnt_in    = '0;
               end
            end else if (last) begin
               rsp_status_in = whp_pkg::STAT_NO_DATA;
               rsp_valid_in  = 1'b1;
               done_in       = 1'b1;
            end
         end

         if (last) begin
            // rearm for the next file
            byte_index_in = 32'd0;
            phase_in      = PH_HEADER;
            held_error_in = whp_pkg::STAT_OK;
            fmt_length_in = 32'd0;
            chans_in      = 16'd0;
            rate_in       = 32'd0;
            skip_left_in  = 32'd0;
            chunk_tag_in  = 32'd0;
            chunk_len_in  = 32'd0;
            done_in       = 1'b0;
         end else if (byte_index_ff != whp_pkg::IDX_MAX) begin
            byte_index_in = byte_index_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= 32'd0;
         phase_ff      <= PH_HEADER;
         held_error_ff <= whp_pkg::STAT_OK;
         fmt_length_ff <= 32'd0;
         chans_ff      <= 16'd0;
         rate_ff       <= 32'd0;
         skip_left_ff  <= 32'd0;
         chunk_tag_ff  <= 32'd0;
         chunk_len_ff  <= 32'd0;
         done_ff       <= 1'b0;
         st_ff         <= ST_IDLE;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_index_ff <= byte_index_in;
         phase_ff      <= phase_in;
         held_error_ff <= held_error_in;
         fmt_length_ff <= fmt_length_in;
         chans_ff      <= chans_in;
         rate_ff       <= rate_in;
         skip_left_ff  <= skip_left_in;
         chunk_tag_ff  <= chunk_tag_in;
         chunk_len_ff  <= chunk_len_in;
         done_ff       <= done_in;
         st_ff         <= st_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chans_ff  <= rsp_chans_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_frames_ff <= rsp_frames_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_frames_ff, rsp_bytes_ff, rsp_off_ff, rsp_rate_ff, rsp_chans_ff};

   `ASSERT_NEVER(a_no_accept_in_div, (st_ff == ST_DIV) && req_tready, "accepted byte while dividing")
   `ASSERT_CLK(a_div_ends_valid, (st_ff == ST_DIV) && (div_cnt_ff == CNT_LAST) |=> rsp_valid_ff, "divide finished without result")
   `ASSERT_NEVER(a_ok_zero_chans, rsp_valid_ff && (rsp_status_ff == whp_pkg::STAT_OK) && (rsp_chans_ff == 16'd0), "ok status with zero channels")
   `ASSERT_NEVER(a_err_no_payload, rsp_valid_ff && (rsp_status_ff != whp_pkg::STAT_OK) && (rsp_status_ff != whp_pkg::STAT_ZERO_CH) && ((rsp_off_ff != 32'd0) || (rsp_bytes_ff != 32'd0)), "error status with payload fields")
   `ASSERT_NEVER(a_header_phase, in_header && (phase_ff != PH_HEADER), "walker active inside header")

endmodule

`default_nettype wire

// ----- tb/sv/wav_header_parser_core_tb.sv -----
`timescale 1ns / 100ps

module wav_header_parser_core_tb;

   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_CYCLES   = 64;
   localparam int RANDOM_BYTES   = 200;
   localparam int FMT_EXTRA_CAP  = 40;
   // "fmt " in file order, low byte first
   localparam logic [31:0] FMT_TAG_LE = 32'h2074_6D66;
   // chunk tags with the first file byte highest
   localparam logic [31:0] LIST_TAG   = 32'h4C49_5354;
   localparam logic [31:0] NEAR_DATA  = 32'h6461_7441;

   typedef enum logic [1:0] {
      PH_HEADER, PH_FMT_SKIP, PH_CHUNK_HDR, PH_CHUNK_BODY
   } walk_phase_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] nch;
      logic [31:0] rate;
      logic [31:0] offset;
      logic [31:0] payload;
      logic [31:0] frames;
   } wav_summary_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic [2:0]   rsp_tuser;

   // parser model state
   logic [31:0]    pos = '0;
   walk_phase_type phase = PH_HEADER;
   logic [2:0]     first_err = whp_pkg::STAT_OK;
   logic [31:0]    fmt_len = '0;
   logic [15:0]    nch = '0;
   logic [31:0]    cur_rate = '0;
   logic [31:0]    skip_left = '0;
   logic [31:0]    tag_acc = '0;
   logic [31:0]    chunk_len = '0;
   logic           done = 1'b0;

   wav_summary_type pending_summaries[$];
   wav_summary_type want;
   logic [7:0]      file_q[$];

   int errors = 0;
   int results_due = 0;
   int results_seen = 0;
   int bytes_sent = 0;
   int files_sent = 0;
   int status_hits[8];

   // idling controls
   bit tx_idle_en = 1'b0;
   bit rx_stall_en = 1'b0;
   int burst_left = 0;
   int hold_asks = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int pat_left = 0;
   int pat_period = 1;
   int pat_stall = 0;

   wav_header_parser_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // parser model
   // ------------------------------------------------------------------
   function automatic void parser_restart();
      pos = '0;
      phase = PH_HEADER;
      first_err = whp_pkg::STAT_OK;
      fmt_len = '0;
      nch = '0;
      cur_rate = '0;
      skip_left = '0;
      tag_acc = '0;
      chunk_len = '0;
      done = 1'b0;
   endfunction

   function automatic void open_chunk_header();
      phase = PH_CHUNK_HDR;
      skip_left = whp_pkg::CHDR_BYTES;
      tag_acc = '0;
      chunk_len = '0;
   endfunction

   // only the first header error in file order is kept
   function automatic void note_error(input logic [2:0] code);
      if (first_err == whp_pkg::STAT_OK) begin
         first_err = code;
      end
   endfunction

   function automatic void header_byte(input logic [31:0] i, input logic [7:0] b);
      if (i < 4) begin
         if (b != whp_pkg::TAG_RIFF_LE[8*i[1:0] +: 8]) note_error(whp_pkg::STAT_NOT_RIFF);
      end else if (i >= 8 && i < 12) begin
         if (b != whp_pkg::TAG_WAVE_LE[8*i[1:0] +: 8]) note_error(whp_pkg::STAT_NOT_WAVE);
      end else if (i >= 16 && i < 20) begin
         fmt_len[8*i[1:0] +: 8] = b;
      end else if (i == 20) begin
         if (b != whp_pkg::PCM_FORMAT) note_error(whp_pkg::STAT_NOT_PCM);
      end else if (i == 21) begin
         if (b != 8'd0) note_error(whp_pkg::STAT_NOT_PCM);
      end else if (i == 22 || i == 23) begin
         nch[8*i[0] +: 8] = b;
      end else if (i >= 24 && i < 28) begin
         cur_rate[8*i[1:0] +: 8] = b;
      end else if (i == 34) begin
         if (b != whp_pkg::PCM_DEPTH) note_error(whp_pkg::STAT_NOT_16BIT);
      end else if (i == 35) begin
         if (b != 8'd0) note_error(whp_pkg::STAT_NOT_16BIT);
      end
      if (i == whp_pkg::HDR_BYTES - 1) begin
         if (fmt_len > whp_pkg::FMT_BASE) begin
            phase = PH_FMT_SKIP;
            skip_left = fmt_len - whp_pkg::FMT_BASE;
         end else begin
            open_chunk_header();
         end
      end
   endfunction

   // true when the data chunk header completes with more bytes to come
   function automatic logic walk_byte(input logic [7:0] b, input logic last);
      logic found;
      found = 1'b0;
      case (phase)
         PH_FMT_SKIP, PH_CHUNK_BODY: begin
            if (skip_left != 0) skip_left--;
            if (skip_left == 0) open_chunk_header();
         end
         PH_CHUNK_HDR: begin
            if (skip_left > whp_pkg::CHDR_TAG_END) tag_acc = {tag_acc[23:0], b};
            else chunk_len = {b, chunk_len[31:8]};
            if (skip_left != 0) skip_left--;
            if (skip_left == 0 && !last) begin
               if (tag_acc == whp_pkg::TAG_DATA) begin
                  found = 1'b1;
               end else if (chunk_len == 0) begin
                  open_chunk_header();
               end else begin
                  phase = PH_CHUNK_BODY;
                  skip_left = chunk_len;
               end
            end
         end
         default: ;
      endcase
      return found;
   endfunction

   function automatic void parse_file_byte(input logic [7:0] b, input logic last);
      wav_summary_type r;
      logic found;
      logic emit;
      if (!done) begin
         found = 1'b0;
         if (pos < whp_pkg::HDR_BYTES) header_byte(pos, b);
         else found = walk_byte(b, last);
         r = '0;
         r.nch = nch;
         r.rate = cur_rate;
         emit = 1'b1;
         if (last && pos < whp_pkg::MIN_LAST) begin
            r.status = whp_pkg::STAT_TOO_SMALL;
         end else if (pos == whp_pkg::MIN_LAST && first_err != whp_pkg::STAT_OK) begin
            r.status = first_err;
         end else if (found) begin
            r.offset = (pos == whp_pkg::IDX_MAX) ? pos : pos + 1;
            r.payload = chunk_len;
            if (nch == 0) begin
               r.status = whp_pkg::STAT_ZERO_CH;
            end else begin
               r.status = whp_pkg::STAT_OK;
               r.frames = chunk_len / {15'd0, nch, 1'b0};
            end
         end else if (last) begin
            r.status = whp_pkg::STAT_NO_DATA;
         end else begin
            emit = 1'b0;
         end
         if (emit) begin
            pending_summaries.push_back(r);
            results_due++;
            done = 1'b1;
         end
      end
      if (last) parser_restart();
      else if (pos != whp_pkg::IDX_MAX) pos++;
   endfunction

   function automatic void check_field(input string what, input logic [31:0] exp_v,
                                       input logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, got_v);
         errors++;
      end
   endfunction

   // accepted bytes feed the model first, then any result is checked
   always @(posedge clock) begin
      if (reset) begin
         parser_restart();
      end else begin
         if (req_tvalid && req_tready) parse_file_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pending_summaries.size() == 0) begin
               $display("%0t: result with no file pending, expected none actual status %0d",
                        $time, rsp_tuser);
               errors++;
            end else begin
               want = pending_summaries.pop_front();
               status_hits[want.status]++;
               check_field("status", {29'd0, want.status}, {29'd0, rsp_tuser});
               check_field("channel_count", {16'd0, want.nch}, {16'd0, rsp_tdata[15:0]});
               check_field("rate_hz", want.rate, rsp_tdata[47:16]);
               check_field("payload_offset", want.offset, rsp_tdata[79:48]);
               check_field("payload_bytes", want.payload, rsp_tdata[111:80]);
               check_field("frame_count", want.frames, rsp_tdata[143:112]);
            end
         end
      end
   end

   // result side: a repeating stall pattern, redrawn whenever its countdown
   // runs out, and a long hold-off on request
   always @(posedge clock) begin
      if (hold_taken != hold_asks) begin
         hold_taken = hold_asks;
         hold_left = LONG_HOLD;
      end
      if (pat_left == 0) begin
         pat_left = 64;
         pat_period = $urandom_range(1, 8);
         pat_stall = rx_stall_en ? $urandom_range(0, pat_period - 1) : 0;
      end
      pat_left--;
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ((pat_left % pat_period) >= pat_stall);
      end
   end

   // ------------------------------------------------------------------
   // file building and sending
   // ------------------------------------------------------------------
   task automatic put_le(input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
   endtask

   task automatic put_rand(input int n);
      repeat (n) file_q.push_back(8'($urandom));
   endtask

   // fresh 36-byte header; extra format bytes are capped to keep files short
   task automatic put_header(input logic [31:0] flen, input logic [15:0] ch,
                             input logic [31:0] hz);
      file_q = {};
      put_le(whp_pkg::TAG_RIFF_LE, 4);
      put_rand(4);
      put_le(whp_pkg::TAG_WAVE_LE, 4);
      put_le(FMT_TAG_LE, 4);
      put_le(flen, 4);
      put_le({24'd0, whp_pkg::PCM_FORMAT}, 2);
      put_le({16'd0, ch}, 2);
      put_le(hz, 4);
      put_rand(6);
      put_le({24'd0, whp_pkg::PCM_DEPTH}, 2);
      if (flen > whp_pkg::FMT_BASE) begin
         put_rand((flen - whp_pkg::FMT_BASE > FMT_EXTRA_CAP) ? FMT_EXTRA_CAP :
                  int'(flen - whp_pkg::FMT_BASE));
      end
   endtask

   task automatic put_chunk(input logic [31:0] tag, input logic [31:0] len, input int nbody);
      for (int i = 3; i >= 0; i--) file_q.push_back(tag[8*i +: 8]);
      put_le(len, 4);
      put_rand(nbody);
   endtask

   // sender works in bursts; a gap may open at the start of each burst
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (tx_idle_en) gap = $urandom_range(0, 6);
      end
      burst_left--;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
      files_sent++;
   endtask

   task automatic send_canonical(input logic [15:0] ch, input logic [31:0] hz,
                                 input logic [31:0] len, input int tail);
      put_header(whp_pkg::FMT_BASE, ch, hz);
      put_chunk(whp_pkg::TAG_DATA, len, tail);
      send_file();
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_good_files();
      tx_idle_en = 1'b0;
      rx_stall_en = 1'b0;
      send_canonical(16'd2, 32'd44100, 32'd1000, 4);
      // field extremes, and bytes after the result that must be ignored
      send_canonical(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      send_canonical(16'd1, 32'd0, 32'd0, 12);
      // zero channels is flagged, not divided
      send_canonical(16'd0, 32'd8000, 32'd64, 3);
   endtask

   task automatic test_chunk_walk();
      tx_idle_en = 1'b1;
      rx_stall_en = 1'b1;
      // extended format, a list chunk, an empty chunk, a near-miss tag
      put_header(32'd18, 16'd2, 32'd48000);
      put_chunk(LIST_TAG, 32'd6, 6);
      put_chunk(32'h6A75_6E6B, 32'd0, 0);
      put_chunk(NEAR_DATA, 32'd3, 3);
      put_chunk(whp_pkg::TAG_DATA, 32'd4096, 2);
      send_file();
      // format length below 16 means no skip
      put_header(32'd7, 16'd6, 32'd96000);
      put_chunk(whp_pkg::TAG_DATA, 32'd1200, 1);
      send_file();
   endtask

   task automatic test_header_errors();
      tx_idle_en = 1'b1;
      rx_stall_en = 1'b1;
      for (int k = 0; k < 9; k++) begin
         put_header(whp_pkg::FMT_BASE, 16'd2, 32'd22050);
         put_chunk(whp_pkg::TAG_DATA, 32'd400, 2);
         case (k)
            0: file_q[0] = 8'h58;
            1: file_q[3] ^= 8'h01;
            2: file_q[9] = 8'h00;
            3: file_q[20] = 8'h03;
            4: file_q[21] = 8'h01;
            5: file_q[34] = 8'h18;
            6: file_q[35] = 8'h80;
            // two faults: the earlier one is reported
            7: begin
               file_q[11] = 8'h00;
               file_q[34] = 8'h08;
            end
            // error held to byte 44, which is also the last byte
            default: begin
               file_q[34] = 8'h20;
               file_q = file_q[0:43];
            end
         endcase
         send_file();
      end
   endtask

   task automatic test_short_files();
      tx_idle_en = 1'b0;
      rx_stall_en = 1'b1;
      // single-byte file
      file_q = {8'h52};
      send_file();
      // 43 bytes: too small
      put_header(whp_pkg::FMT_BASE, 16'd2, 32'd44100);
      put_chunk(whp_pkg::TAG_DATA, 32'd100, 0);
      file_q = file_q[0:42];
      send_file();
      // 44 bytes: data header ends the file, so no data
      put_header(whp_pkg::FMT_BASE, 16'd2, 32'd44100);
      put_chunk(whp_pkg::TAG_DATA, 32'd100, 0);
      send_file();
      // end of file inside the format skip
      put_header(32'h0001_0000, 16'd2, 32'd44100);
      send_file();
      // end inside a chunk body
      put_header(whp_pkg::FMT_BASE, 16'd1, 32'd16000);
      put_chunk(LIST_TAG, 32'd100, 10);
      send_file();
      // end partway through a chunk header
      put_header(whp_pkg::FMT_BASE, 16'd1, 32'd16000);
      put_chunk(LIST_TAG, 32'd2, 2);
      put_chunk(whp_pkg::TAG_DATA, 32'd50, 0);
      file_q = file_q[0:file_q.size() - 4];
      send_file();
   endtask

   // results held off while the sender keeps offering bytes
   task automatic test_backpressure();
      tx_idle_en = 1'b0;
      rx_stall_en = 1'b0;
      hold_asks++;
      repeat (3) send_canonical(16'($urandom_range(1, 4)), $urandom, $urandom_range(0, 9999), 2);
   endtask

   task automatic build_random_file();
      int kind;
      int nchunk;
      int cut;
      int at;
      logic [31:0] flen;
      logic [31:0] tag;
      logic [31:0] len;
      logic [15:0] ch;
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0: ch = 16'd0;
         1: ch = 16'($urandom);
         2: ch = 16'hFFFF;
         default: ch = 16'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
         0, 1: flen = $urandom_range(0, 15);
         2, 3: flen = $urandom_range(17, 40);
         4: flen = $urandom | 32'h1000;
         default: flen = whp_pkg::FMT_BASE;
      endcase
      put_header(flen, ch, $urandom);
      if (kind < 15) begin
         repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(0, 5))
               0: at = $urandom_range(0, 3);
               1: at = $urandom_range(8, 11);
               2: at = 20;
               3: at = 21;
               4: at = 34;
               default: at = 35;
            endcase
            file_q[at] ^= 8'($urandom_range(1, 255));
         end
      end
      nchunk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (nchunk) begin
         tag = $urandom;
         if ($urandom_range(0, 3) == 0) begin
            tag = whp_pkg::TAG_DATA ^ (32'h1 << $urandom_range(0, 31));
         end
         if (tag == whp_pkg::TAG_DATA) tag ^= 32'h1;
         len = $urandom_range(0, 12);
         put_chunk(tag, len, len);
      end
      case ($urandom_range(0, 5))
         0: len = $urandom;
         1: len = whp_pkg::IDX_MAX;
         2: len = 32'd0;
         default: len = $urandom_range(1, 4000);
      endcase
      put_chunk(whp_pkg::TAG_DATA, len, $urandom_range(1, 5));
      if (kind >= 15 && kind < 30) begin
         cut = $urandom_range(1, file_q.size());
         file_q = file_q[0:cut - 1];
      end else if (kind >= 30 && kind < 36) begin
         file_q = {};
         put_rand($urandom_range(1, 60));
      end
   endtask

   task automatic test_random_files();
      int start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < RANDOM_BYTES) begin
         tx_idle_en = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 7) == 0) rx_stall_en = !rx_stall_en;
         build_random_file();
         send_file();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_good_files();
      test_chunk_walk();
      test_header_errors();
      test_short_files();
      test_backpressure();
      test_random_files();
      req_tvalid <= 1'b0;
      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d files, %0d bytes, %0d results checked", files_sent, bytes_sent,
               results_seen);
      $display("status mix ok/small/riff/wave/pcm/depth/nodata/zeroch: %0d %0d %0d %0d %0d %0d %0d %0d",
               status_hits[whp_pkg::STAT_OK], status_hits[whp_pkg::STAT_TOO_SMALL],
               status_hits[whp_pkg::STAT_NOT_RIFF], status_hits[whp_pkg::STAT_NOT_WAVE],
               status_hits[whp_pkg::STAT_NOT_PCM], status_hits[whp_pkg::STAT_NOT_16BIT],
               status_hits[whp_pkg::STAT_NO_DATA], status_hits[whp_pkg::STAT_ZERO_CH]);
      if (errors == 0 && pending_summaries.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", pending_summaries.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
